### src/tks_pkg.sv
// Shared constants and types for the top-k sorted insertion table.
`timescale 1ns / 1ps
`default_nettype none

package tks_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int NAME_CHARS_DEF    = 8;

    localparam int SCORE_W     = 32;
    localparam int NAME_PORT_W = 64;
    localparam int IDX_W       = 3;
    localparam int RANK_W      = 3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // Update control handed to each cell of the chain
    typedef struct packed {
        logic upd;      // insert transaction accepted this cycle
        logic up_take;  // cell above also moves, so copy its contents
    } tks_ctl_t;

endpackage

`default_nettype wire

### src/tks_cell.sv
// One slot of the sorted table: holds an entry and shifts or loads on insert.
`timescale 1ns / 1ps
`default_nettype none

module tks_cell #(
    parameter int NAME_W = 8 * tks_pkg::NAME_CHARS_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire tks_pkg::tks_ctl_t             ctl,
    input  wire                                up_full,
    input  wire signed [tks_pkg::SCORE_W-1:0]  up_score,
    input  wire        [NAME_W-1:0]            up_name,
    input  wire signed [tks_pkg::SCORE_W-1:0]  new_score,
    input  wire        [NAME_W-1:0]            new_name,
    output logic                               take,
    output logic                               full,
    output logic signed [tks_pkg::SCORE_W-1:0] score,
    output logic        [NAME_W-1:0]           name
);

    logic                               full_reg;
    logic                               full_next;
    logic signed [tks_pkg::SCORE_W-1:0] score_reg;
    logic signed [tks_pkg::SCORE_W-1:0] score_next;
    logic        [NAME_W-1:0]           name_reg;
    logic        [NAME_W-1:0]           name_next;

    // Empty slot or strictly lower score: the new entry belongs here or above
    assign take = !full_reg || (score_reg < new_score);

    always_comb
    begin
        full_next  = full_reg;
        score_next = score_reg;
        name_next  = name_reg;
        if (ctl.upd && take)
        begin
            if (ctl.up_take)
            begin
                full_next  = up_full;
                score_next = up_score;
                name_next  = up_name;
            end
            else
            begin
                full_next  = 1'b1;
                score_next = new_score;
                name_next  = new_name;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        name_reg  <= name_next;
    end

    assign full  = full_reg;
    assign score = score_reg;
    assign name  = name_reg;

endmodule

`default_nettype wire

### src/top_k_sorted_insert.sv
// Top level of the top-k sorted insertion table: cell chain and result register.
//
// Usage: one input channel (in_valid/in_ready) carries transactions with mode,
// new_score, new_name and slot_index. mode insert places the entry below every
// stored entry with a greater or equal score; mode read returns one slot.
// Each input transaction yields exactly one result transaction on the output
// channel (out_valid/out_ready): accepted and placed_rank for an insert,
// slot_valid, slot_score and slot_name for a read; unused fields are zero.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one transaction per cycle while out_ready is high. Every cell compares its score with
// the new score in parallel and shifts or loads in the same edge, so the
// next transaction already sees the updated table.
// Stall: while a result waits and out_ready is low, in_ready drops; the
// result register holds. When out_ready is high a new transaction is taken
// in the same cycle the waiting result leaves.
// Reset: rst_n (asynchronous, active low) empties the table at once and
// clears the result valid flag; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module top_k_sorted_insert #(
    parameter int TABLE_ENTRIES = tks_pkg::TABLE_ENTRIES_DEF,
    parameter int NAME_CHARS    = tks_pkg::NAME_CHARS_DEF
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire                                    mode,
    input  wire signed [tks_pkg::SCORE_W-1:0]      new_score,
    input  wire        [tks_pkg::NAME_PORT_W-1:0]  new_name,
    input  wire        [tks_pkg::IDX_W-1:0]        slot_index,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output logic                                   accepted,
    output logic       [tks_pkg::RANK_W-1:0]       placed_rank,
    output logic                                   slot_valid,
    output logic signed [tks_pkg::SCORE_W-1:0]     slot_score,
    output logic       [tks_pkg::NAME_PORT_W-1:0]  slot_name
);

    localparam int NAME_W = 8 * NAME_CHARS;
    localparam int N      = TABLE_ENTRIES;
    // Only slots reachable by a 3-bit index can be read
    localparam int RD_N   = (N < (1 << tks_pkg::IDX_W)) ? N : (1 << tks_pkg::IDX_W);

    logic                               in_acc;
    logic                               upd;
    logic [NAME_W-1:0]                  new_name_w;

    logic [N-1:0]                       take_vec;
    logic [N-1:0]                       full_vec;
    logic signed [tks_pkg::SCORE_W-1:0] score_a [N];
    logic        [NAME_W-1:0]           name_a  [N];

    logic                               any_take;
    logic [tks_pkg::RANK_W-1:0]         rank_c;
    logic                               rd_hit;
    logic signed [tks_pkg::SCORE_W-1:0] rd_score;
    logic        [NAME_W-1:0]           rd_name;

    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic                                   accepted_reg;
    logic                                   accepted_next;
    logic [tks_pkg::RANK_W-1:0]             placed_rank_reg;
    logic [tks_pkg::RANK_W-1:0]             placed_rank_next;
    logic                                   slot_valid_reg;
    logic                                   slot_valid_next;
    logic signed [tks_pkg::SCORE_W-1:0]     slot_score_reg;
    logic signed [tks_pkg::SCORE_W-1:0]     slot_score_next;
    logic [tks_pkg::NAME_PORT_W-1:0]        slot_name_reg;
    logic [tks_pkg::NAME_PORT_W-1:0]        slot_name_next;

    // Take a new transaction whenever the result register is free or draining
    assign in_ready   = !out_valid_reg || out_ready;
    assign in_acc     = in_valid && in_ready;
    assign upd        = in_acc && (mode == tks_pkg::MODE_INSERT);
    assign new_name_w = new_name[NAME_W-1:0];

    // Cell chain: slot 0 on top, each cell copies from the one above on shift
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        tks_pkg::tks_ctl_t ctl;
        logic                               up_full;
        logic signed [tks_pkg::SCORE_W-1:0] up_score;
        logic        [NAME_W-1:0]           up_name;

        if (i == 0)
        begin : g_head
            assign ctl.up_take = 1'b0;
            assign up_full     = 1'b0;
            assign up_score    = '0;
            assign up_name     = '0;
        end
        else
        begin : g_body
            assign ctl.up_take = take_vec[i-1];
            assign up_full     = full_vec[i-1];
            assign up_score    = score_a[i-1];
            assign up_name     = name_a[i-1];
        end
        assign ctl.upd = upd;

        tks_cell #(
            .NAME_W (NAME_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .up_full   (up_full),
            .up_score  (up_score),
            .up_name   (up_name),
            .new_score (new_score),
            .new_name  (new_name_w),
            .take      (take_vec[i]),
            .full      (full_vec[i]),
            .score     (score_a[i]),
            .name      (name_a[i])
        );
    end

    // take_vec is a run of ones from the first insertion point down,
    // so the lowest cell tells whether the insert is rejected
    assign any_take = take_vec[N-1];

    // Encode the first taking cell; the rank keeps the low three bits
    always_comb
    begin
        rank_c = '0;
        for (int i = 0; i < N; i++)
        begin
            if (take_vec[i] && ((i == 0) || !take_vec[(i == 0) ? 0 : i - 1]))
            begin
                rank_c = rank_c | tks_pkg::RANK_W'(i);
            end
        end
    end

    // Read mux over the addressable slots; a slot past the table reads empty
    always_comb
    begin
        rd_hit   = 1'b0;
        rd_score = '0;
        rd_name  = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (slot_index == tks_pkg::IDX_W'(i))
            begin
                rd_hit   = full_vec[i];
                rd_score = score_a[i];
                rd_name  = name_a[i];
            end
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg && !out_ready;
        accepted_next    = accepted_reg;
        placed_rank_next = placed_rank_reg;
        slot_valid_next  = slot_valid_reg;
        slot_score_next  = slot_score_reg;
        slot_name_next   = slot_name_reg;
        if (in_acc)
        begin
            out_valid_next   = 1'b1;
            accepted_next    = 1'b0;
            placed_rank_next = '0;
            slot_valid_next  = 1'b0;
            slot_score_next  = '0;
            slot_name_next   = '0;
            if (mode == tks_pkg::MODE_READ)
            begin
                if (rd_hit)
                begin
                    slot_valid_next = 1'b1;
                    slot_score_next = rd_score;
                    slot_name_next  = tks_pkg::NAME_PORT_W'(rd_name);
                end
            end
            else if (any_take)
            begin
                accepted_next    = 1'b1;
                placed_rank_next = rank_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: hold while stalled
    always_ff @(posedge clk)
    begin
        accepted_reg    <= accepted_next;
        placed_rank_reg <= placed_rank_next;
        slot_valid_reg  <= slot_valid_next;
        slot_score_reg  <= slot_score_next;
        slot_name_reg   <= slot_name_next;
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign placed_rank = placed_rank_reg;
    assign slot_valid  = slot_valid_reg;
    assign slot_score  = slot_score_reg;
    assign slot_name   = slot_name_reg;

    // Occupied slots always form a run from slot 0
    a_full_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((full_vec & (full_vec + N'(1))) == '0))
        else $error("occupied slots not contiguous from slot 0");

    // A rejected insert leaves occupancy unchanged
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && !any_take) |=> (full_vec == $past(full_vec)))
        else $error("rejected insert changed the table");

    // An insert into a table with room adds exactly one entry
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && any_take && !full_vec[N-1])
        |=> ($countones(full_vec) == $countones($past(full_vec)) + 1))
        else $error("insert did not add exactly one entry");

    // Every accepted transaction produces a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg)
        else $error("accepted transaction produced no result");

endmodule

`default_nettype wire

### verif/tb_top.sv
// Testbench for the top-k sorted insertion table: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_SLOTS = tks_pkg::TABLE_ENTRIES_DEF;
    localparam logic [tks_pkg::NAME_PORT_W-1:0] NAME_KEEP =
        (tks_pkg::NAME_CHARS_DEF >= 8) ? '1
                                       : ((64'd1 << (8 * tks_pkg::NAME_CHARS_DEF)) - 64'd1);
    localparam logic signed [tks_pkg::SCORE_W-1:0] SCORE_MAX = 32'sh7fff_ffff;
    localparam logic signed [tks_pkg::SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

    // One result transaction as the block presents it
    typedef struct packed {
        logic                                accepted;
        logic [tks_pkg::RANK_W-1:0]          placed_rank;
        logic                                slot_valid;
        logic signed [tks_pkg::SCORE_W-1:0]  slot_score;
        logic [tks_pkg::NAME_PORT_W-1:0]     slot_name;
    } table_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic                                mode = tks_pkg::MODE_INSERT;
    logic signed [tks_pkg::SCORE_W-1:0]  new_score = '0;
    logic [tks_pkg::NAME_PORT_W-1:0]     new_name = '0;
    logic [tks_pkg::IDX_W-1:0]           slot_index = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic                                accepted;
    logic [tks_pkg::RANK_W-1:0]          placed_rank;
    logic                                slot_valid;
    logic signed [tks_pkg::SCORE_W-1:0]  slot_score;
    logic [tks_pkg::NAME_PORT_W-1:0]     slot_name;

    // Predicted copy of the ranking table; occupancy lives in held[]
    logic                                held       [NUM_SLOTS] = '{default: 1'b0};
    logic signed [tks_pkg::SCORE_W-1:0]  held_score [NUM_SLOTS] = '{default: '0};
    logic [tks_pkg::NAME_PORT_W-1:0]     held_name  [NUM_SLOTS] = '{default: '0};

    table_result_t                  pending_results[$];
    int                             mismatches = 0;

    // Idle knobs: sender gap length and receiver stall length (0 disables)
    int                             tx_gap_max = 0;
    int                             tx_burst_left = 0;
    int                             rx_stall_max = 0;
    int                             rx_run_left = 0;
    int                             rx_hold_left = 0;

    top_k_sorted_insert i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .new_score   (new_score),
        .new_name    (new_name),
        .slot_index  (slot_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .placed_rank (placed_rank),
        .slot_valid  (slot_valid),
        .slot_score  (slot_score),
        .slot_name   (slot_name)
    );

    always #2 clk = ~clk;

    // Apply one transaction to the predicted table and return the result it earns.
    // An insert lands below every held entry with a greater or equal score, so a
    // tie goes after the older entries; the bottom entry falls off a full table.
    function automatic table_result_t apply_to_table(
        logic                               op,
        logic signed [tks_pkg::SCORE_W-1:0] score,
        logic [tks_pkg::NAME_PORT_W-1:0]    name,
        logic [tks_pkg::IDX_W-1:0]          idx);
        table_result_t res;
        int            pos;
        res = '0;
        pos = NUM_SLOTS;
        if (op == tks_pkg::MODE_READ) begin
            // Empty slots and slots past the table read as all zero
            if (int'(idx) < NUM_SLOTS && held[idx]) begin
                res.slot_valid = 1'b1;
                res.slot_score = held_score[idx];
                res.slot_name  = held_name[idx];
            end
            return res;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
            if (pos == NUM_SLOTS && (!held[i] || held_score[i] < score))
                pos = i;
        // No such slot: full table whose last score is not below the new one
        if (pos < NUM_SLOTS) begin
            for (int i = NUM_SLOTS - 1; i > pos; i--) begin
                held[i]       = held[i - 1];
                held_score[i] = held_score[i - 1];
                held_name[i]  = held_name[i - 1];
            end
            held[pos]        = 1'b1;
            held_score[pos]  = score;
            held_name[pos]   = name & NAME_KEEP;
            res.accepted     = 1'b1;
            res.placed_rank  = tks_pkg::RANK_W'(pos);
        end
        return res;
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    // Check each result against the oldest prediction, then predict for any input
    // transaction taken at this edge. Both sample pre-edge values only.
    always @(posedge clk) begin : result_check
        table_result_t want;
        if (out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no prediction waiting");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("accepted", 64'(want.accepted), 64'(accepted));
                check_field("placed_rank", 64'(want.placed_rank), 64'(placed_rank));
                check_field("slot_valid", 64'(want.slot_valid), 64'(slot_valid));
                check_field("slot_score", 64'(want.slot_score), 64'(slot_score));
                check_field("slot_name", want.slot_name, slot_name);
            end
        end
        if (in_valid && in_ready)
            pending_results.push_back(apply_to_table(mode, new_score, new_name, slot_index));
    end

    // Receiver: runs of ready cycles broken by stalls of random length
    always @(negedge clk) begin : rx_pattern
        logic nxt;
        if (rx_stall_max == 0) begin
            nxt = 1'b1;
        end else if (rx_run_left > 0) begin
            nxt = 1'b1;
            rx_run_left--;
        end else if (rx_hold_left > 0) begin
            nxt = 1'b0;
            rx_hold_left--;
        end else begin
            rx_run_left  = $urandom_range(0, 10);
            rx_hold_left = $urandom_range(0, rx_stall_max - 1);
            nxt          = 1'b0;
        end
        out_ready <= nxt;
    end

    // Present one transaction and hold it until the block takes it. Valid stays
    // high on return; the next call or a drain replaces it at the next falling edge.
    task automatic send_item(logic op, logic signed [tks_pkg::SCORE_W-1:0] score,
                             logic [tks_pkg::NAME_PORT_W-1:0] name,
                             logic [tks_pkg::IDX_W-1:0] idx);
        int gap;
        gap = 0;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 12);
            if (tx_gap_max > 0)
                gap = $urandom_range(1, tx_gap_max);
        end
        tx_burst_left--;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        new_score  <= score;
        new_name   <= name;
        slot_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every predicted result has been checked
    task automatic wait_for_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Reads of an empty table; payload fields that do not apply are driven busy
    task automatic test_empty_reads();
        tx_gap_max   = 3;
        rx_stall_max = 4;
        send_item(tks_pkg::MODE_READ, SCORE_MAX, '1, 3'd0);
        send_item(tks_pkg::MODE_READ, SCORE_MIN, 64'h0123_4567_89ab_cdef, 3'd7);
        send_item(tks_pkg::MODE_READ, 32'sd1, '0, 3'd3);
    endtask

    // Score extremes, an all-zero name, a tie, and reads across the filled/empty edge
    task automatic test_extremes_and_ties();
        send_item(tks_pkg::MODE_INSERT, SCORE_MAX, '1, 3'd7);
        send_item(tks_pkg::MODE_INSERT, SCORE_MIN, '0, 3'd5);
        send_item(tks_pkg::MODE_INSERT, 32'sd0, 64'h5555_aaaa_5555_aaaa, 3'd2);
        send_item(tks_pkg::MODE_INSERT, 32'sd0, 64'haaaa_5555_aaaa_5555, 3'd1);
        for (int s = 0; s < 5; s++)
            send_item(tks_pkg::MODE_READ, SCORE_MAX, '1, tks_pkg::IDX_W'(s));
    endtask

    // Fill the table, then reject on a tie with the bottom and evict on a better score
    task automatic test_fill_and_reject();
        send_item(tks_pkg::MODE_INSERT, -32'sd5, {$urandom, $urandom}, 3'd0);
        send_item(tks_pkg::MODE_INSERT, 32'sd100, {$urandom, $urandom}, 3'd6);
        send_item(tks_pkg::MODE_INSERT, 32'sd0, {$urandom, $urandom}, 3'd4);
        send_item(tks_pkg::MODE_INSERT, 32'sd7, {$urandom, $urandom}, 3'd3);
        send_item(tks_pkg::MODE_INSERT, SCORE_MIN, 64'hdead_beef_0000_0001, 3'd7);
        send_item(tks_pkg::MODE_INSERT, SCORE_MIN + 32'sd1, 64'h0000_0001_dead_beef, 3'd0);
        send_item(tks_pkg::MODE_INSERT, SCORE_MIN + 32'sd1, 64'hffff_0000_ffff_0000, 3'd0);
        send_item(tks_pkg::MODE_READ, 32'sd0, '0, 3'd6);
        send_item(tks_pkg::MODE_READ, 32'sd0, '0, 3'd7);
    endtask

    // Random mix biased toward the scores already held, so that ties, evictions
    // and rejects keep happening once the table is full.
    task automatic test_random_traffic(int items, int gap_max, int stall_max);
        int                                 pick;
        int                                 slot;
        logic signed [tks_pkg::SCORE_W-1:0] score;
        logic [tks_pkg::NAME_PORT_W-1:0]    name;
        tx_gap_max   = gap_max;
        rx_stall_max = stall_max;
        repeat (items) begin
            pick  = $urandom_range(0, 99);
            slot  = $urandom_range(0, NUM_SLOTS - 1);
            name  = {$urandom, $urandom};
            score = $urandom;
            if ($urandom_range(0, 15) == 0)
                name = ($urandom_range(0, 1) != 0) ? '1 : '0;
            if (pick < 35) begin
                send_item(tks_pkg::MODE_READ, score, name,
                          tks_pkg::IDX_W'($urandom_range(0, 7)));
            end else begin
                if (pick < 55)
                    // tie with a held entry; keep the top score rare so the table
                    // seldom saturates
                    score = (held_score[slot] == SCORE_MAX) ? SCORE_MAX - 32'sd1
                                                            : held_score[slot];
                else if (pick < 70)
                    score = held_score[slot] + 32'sd1;
                else if (pick < 80)
                    score = held_score[NUM_SLOTS - 1] - 32'($urandom_range(0, 3));
                else if (pick < 90)
                    score = held_score[NUM_SLOTS - 1] + 32'($urandom_range(1, 1000));
                else if (pick < 99)
                    score = ($urandom_range(0, 3) == 0) ? SCORE_MIN : score;
                else
                    score = SCORE_MAX;
                send_item(tks_pkg::MODE_INSERT, score, name,
                          tks_pkg::IDX_W'($urandom_range(0, 7)));
            end
        end
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_reads();
        test_extremes_and_ties();
        test_fill_and_reject();
        wait_for_all_results();

        // Back-to-back first, then idling on each side, then both together
        test_random_traffic(175, 0, 0);
        wait_for_all_results();
        test_random_traffic(175, 6, 0);
        wait_for_all_results();
        test_random_traffic(175, 0, 8);
        wait_for_all_results();
        test_random_traffic(175, 8, 12);
        wait_for_all_results();

        // Let any stray result show up before the verdict
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
